// ===== rtl/hbs_pkg.sv =====
package hbs_pkg;

	// Field and register widths
	localparam int OP_W  = 3;
	localparam int IDX_W = 12;
	localparam int POS_W = 13;

	typedef logic [OP_W-1:0] op_t;

	// Operation codes
	localparam op_t OP_SET        = 3'd0;
	localparam op_t OP_CLEAR      = 3'd1;
	localparam op_t OP_FIND_FIRST = 3'd2;
	localparam op_t OP_FIND_NEXT  = 3'd3;
	localparam op_t OP_FIND_LAST  = 3'd4;

	// Reset value of the bits-in-use register
	localparam logic [POS_W-1:0] BITS_IN_USE_RST = 13'd4096;

	// Shift of the reciprocal used to split a position into word and bit
	localparam int DIV_SH = 20;

endpackage

// ===== rtl/hbs_prienc.sv =====
module hbs_prienc #(
	parameter int W = 64
) (
	input  logic [W-1:0]         vec,
	input  logic                 high,
	output logic                 any,
	output logic [$clog2(W)-1:0] idx
);

	localparam int IW = $clog2(W);

	// Pick the lowest or the highest set bit
	always_comb begin
		any = |vec;
		idx = '0;
		if (high) begin
			for (int i = 0; i < W; i++) begin
				if (vec[i]) idx = IW'(i);
			end
		end else begin
			for (int i = W - 1; i >= 0; i--) begin
				if (vec[i]) idx = IW'(i);
			end
		end
	end

endmodule

// ===== rtl/hierarchical_bitmap_search_top.sv =====
// Set and clear fetch the leaf word, then write it back; out of range they go straight to idle.
// Find first searches the summary, then the picked leaf word, or ends on an empty summary; find
// next and find last search the first word, then on a miss the summary and the picked word, and
// end without a search when the start is out of range; one shared encoder serves each search.
// One item at a time, cmd_stall high outside idle; a waiting result stalls the sequencer.
// Reset clears summary, sequencer and output valid, sets bits_in_use to 4096; no leaf clear pass.
module hierarchical_bitmap_search_top import hbs_pkg::*; #(
	parameter int TOTAL_BITS = 4096,
	parameter int WORD_BITS  = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [POS_W-1:0] wr_data,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  op_t              op,
	input  logic [IDX_W-1:0] index,
	output logic             res_valid,
	input  logic             res_stall,
	output logic             found,
	output logic [IDX_W-1:0] position
);

	localparam int LEAF_COUNT = TOTAL_BITS / WORD_BITS;
	localparam int LW         = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1;
	localparam int BW         = $clog2(WORD_BITS);
	localparam int EW         = (WORD_BITS > LEAF_COUNT) ? WORD_BITS : LEAF_COUNT;
	localparam int EIW        = $clog2(EW);
	localparam int RECIP      = (1 << DIV_SH) / WORD_BITS + 1;
	localparam int RECIP_W    = $clog2(RECIP + 1);
	localparam int PROD_W     = POS_W + RECIP_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FETCH  = 3'd1;
	localparam logic [2:0] S_UPDATE = 3'd2;
	localparam logic [2:0] S_LEAF1  = 3'd3;
	localparam logic [2:0] S_SUM    = 3'd4;
	localparam logic [2:0] S_LEAF2  = 3'd5;
	localparam logic [2:0] S_RESULT = 3'd6;

	logic [2:0]            state_q;
	op_t                   op_q;
	logic [LW-1:0]         word_q;
	logic [POS_W-1:0]      pos_q;
	logic [BW-1:0]         bit_q;
	logic [POS_W-1:0]      bits_in_use_q;
	logic [LEAF_COUNT-1:0] summary_q;
	logic [WORD_BITS-1:0]  mem_q [LEAF_COUNT];
	logic [WORD_BITS-1:0]  rdata_q;
	logic                  rd_ok_q;
	logic                  res_found_q;
	logic [POS_W-1:0]      res_pos_q;
	logic                  out_valid_q;
	logic                  found_q;
	logic [IDX_W-1:0]      position_q;

	logic [POS_W-1:0]      lim;
	logic                  accept;
	logic [POS_W-1:0]      next_pos;
	logic [POS_W-1:0]      div_in;
	logic [PROD_W-1:0]     prod;
	logic [POS_W-1:0]      quot;
	logic                  quot_ok;
	logic [WORD_BITS-1:0]  leaf_word;
	logic [WORD_BITS-1:0]  leaf_masked;
	logic [LEAF_COUNT-1:0] sum_masked;
	logic [WORD_BITS-1:0]  bit_sel;
	logic [WORD_BITS-1:0]  upd_word;
	logic [POS_W-1:0]      leaf_base;
	logic [POS_W-1:0]      hit_pos;
	logic                  hit_ok;
	logic [EW-1:0]         enc_vec;
	logic                  enc_high;
	logic                  enc_any;
	logic [EIW-1:0]        enc_idx;
	logic [LW-1:0]         rd_addr;
	logic                  out_free;

	// Effective limit, saturated at the bitmap size
	assign lim = (bits_in_use_q > POS_W'(TOTAL_BITS)) ? POS_W'(TOTAL_BITS) : bits_in_use_q;

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign next_pos  = POS_W'(index) + POS_W'(1);

	// Pick the position to split into word and bit
	always_comb begin
		case (op)
			OP_FIND_NEXT: div_in = next_pos;
			OP_FIND_LAST: div_in = lim - POS_W'(1);
			default:      div_in = POS_W'(index);
		endcase
	end

	// Divide by the word size through a reciprocal
	assign prod    = PROD_W'(div_in) * PROD_W'(RECIP);
	assign quot    = POS_W'(prod >> DIV_SH);
	assign quot_ok = (quot < POS_W'(LEAF_COUNT));

	// Leaf word as read; a clear summary bit means the word is zero
	assign leaf_word = rd_ok_q ? rdata_q : '0;

	// Set or clear one bit of the fetched word
	assign bit_sel  = WORD_BITS'(1) << bit_q;
	assign upd_word = (op_q == OP_SET) ? (leaf_word | bit_sel) : (leaf_word & ~bit_sel);

	// Mask the fetched leaf word to the search window
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			if (op_q == OP_FIND_LAST) leaf_masked[j] = leaf_word[j] && (j <= int'(bit_q));
			else                      leaf_masked[j] = leaf_word[j] && (j >= int'(bit_q));
		end
	end

	// Mask the summary to the words still to be searched
	always_comb begin
		for (int i = 0; i < LEAF_COUNT; i++) begin
			case (op_q)
				OP_FIND_NEXT: sum_masked[i] = summary_q[i] && (i > int'(word_q));
				OP_FIND_LAST: sum_masked[i] = summary_q[i] && (i < int'(word_q));
				default:      sum_masked[i] = summary_q[i];
			endcase
		end
	end

	// Feed the shared priority encoder
	always_comb begin
		case (state_q)
			S_SUM:   enc_vec = EW'(sum_masked);
			S_LEAF1: enc_vec = EW'(leaf_masked);
			default: enc_vec = EW'(leaf_word);
		endcase
	end

	assign enc_high = (op_q == OP_FIND_LAST);

	hbs_prienc #(
		.W (EW)
	) u_prienc (
		.vec  (enc_vec),
		.high (enc_high),
		.any  (enc_any),
		.idx  (enc_idx)
	);

	// Bitmap position of the encoder hit in the current word
	assign leaf_base = POS_W'(word_q) * POS_W'(WORD_BITS);
	assign hit_pos   = leaf_base + POS_W'(enc_idx[BW-1:0]);
	assign hit_ok    = (hit_pos < lim);

	assign rd_addr = (state_q == S_SUM) ? enc_idx[LW-1:0] : word_q;

	// Leaf memory: write back on update, registered read every cycle
	always_ff @(posedge clk) begin
		if (state_q == S_UPDATE) mem_q[word_q] <= upd_word;
		rdata_q <= mem_q[rd_addr];
		rd_ok_q <= summary_q[rd_addr];
	end

	// Hold the bits-in-use register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_in_use_q <= BITS_IN_USE_RST;
		end else if (wr_en) begin
			bits_in_use_q <= wr_data;
		end
	end

	assign out_free = !out_valid_q || !res_stall;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_SET;
			word_q      <= '0;
			pos_q       <= '0;
			bit_q       <= '0;
			summary_q   <= '0;
			res_found_q <= 1'b0;
			res_pos_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q        <= op;
						pos_q       <= div_in;
						word_q      <= quot[LW-1:0];
						res_found_q <= 1'b0;
						res_pos_q   <= '0;
						case (op)
							OP_SET, OP_CLEAR: begin
								state_q <= (POS_W'(index) < lim && quot_ok) ? S_FETCH : S_IDLE;
							end
							OP_FIND_FIRST: state_q <= S_SUM;
							OP_FIND_NEXT: begin
								state_q <= (next_pos < lim && quot_ok) ? S_FETCH : S_RESULT;
							end
							OP_FIND_LAST: begin
								state_q <= (lim != '0 && quot_ok) ? S_FETCH : S_RESULT;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_FETCH: begin
					bit_q   <= BW'(pos_q - leaf_base);
					state_q <= (op_q == OP_SET || op_q == OP_CLEAR) ? S_UPDATE : S_LEAF1;
				end
				S_UPDATE: begin
					summary_q[word_q] <= |upd_word;
					state_q           <= S_IDLE;
				end
				S_LEAF1: begin
					if (enc_any) begin
						res_found_q <= hit_ok;
						res_pos_q   <= hit_ok ? hit_pos : '0;
						state_q     <= S_RESULT;
					end else begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (enc_any) begin
						word_q  <= enc_idx[LW-1:0];
						state_q <= S_LEAF2;
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_LEAF2: begin
					res_found_q <= hit_ok;
					res_pos_q   <= hit_ok ? hit_pos : '0;
					state_q     <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: load on result, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && out_free) begin
			found_q    <= res_found_q;
			position_q <= res_pos_q[IDX_W-1:0];
		end
	end

	assign res_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;

	// A word picked from the summary is never empty
	a_leaf2_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LEAF2 |-> enc_any)
		else $error("summary pointed at an empty leaf word");

	// A reported hit lies below the limit
	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && res_found_q) |-> res_pos_q < lim)
		else $error("hit reported at or above the limit");

	// Summary bit follows the written leaf word
	a_summary_track: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPDATE |=> summary_q[$past(word_q)] == $past(|upd_word))
		else $error("summary bit out of step with leaf word");

	// No position without a hit
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !found) |-> position == '0)
		else $error("position nonzero on a miss");

endmodule
